/* sv/csu_pkg.sv */
// Shared types, character codes and helper functions for the capability string unescaper.
`timescale 1ns / 1ps

package csu_pkg;

    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LIMIT_W = 10;

    localparam logic REG_SEP_COLON  = 1'b0;
    localparam logic REG_LONG_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] COUNT_MAX   = 10'd1023;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd600;

    localparam logic [7:0] CTRL_MASK  = 8'o037;
    localparam logic [7:0] OCTAL_ZERO = 8'o200;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BSPACE  = 8'h08;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [1:0] {
        PH_NORMAL    = 2'd0,
        PH_CARET     = 2'd1,
        PH_BACKSLASH = 2'd2,
        PH_OCTAL     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_SEP       = 2'd1,
        KIND_EOI       = 2'd2,
        KIND_PREMATURE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       bad_caret;
        logic       bad_escape;
        logic       too_long;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]        num;
        t_result [1:0]     res;
    } t_push;

    typedef struct packed {
        logic               separator_is_colon;
        logic [LIMIT_W-1:0] long_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] value;
        logic       bad;
    } t_esc;

    function automatic logic [LIMIT_W-1:0] sat_inc(input logic [LIMIT_W-1:0] x);
        return (x == COUNT_MAX) ? x : x + 1'b1;
    endfunction

    function automatic t_result byte_result(input logic [7:0] b, input logic bc,
                                            input logic be, input logic tl);
        t_result r;
        r.kind       = KIND_BYTE;
        r.out_byte   = b;
        r.bad_caret  = bc;
        r.bad_escape = be;
        r.too_long   = tl;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_result end_result(input t_kind k);
        t_result r;
        r            = '0;
        r.kind       = k;
        return r;
    endfunction

    function automatic t_esc esc_map(input logic [7:0] c);
        t_esc e;
        e.bad = 1'b0;
        unique case (c) inside
            "E", "e": e.value = CH_ESC;
            "l", "n": e.value = CH_LF;
            "r":      e.value = CH_CR;
            "b":      e.value = CH_BSPACE;
            "s":      e.value = CH_SPACE;
            "f":      e.value = CH_FFEED;
            "t":      e.value = CH_TAB;
            CH_BSLASH: e.value = CH_BSLASH;
            CH_CARET:  e.value = CH_CARET;
            CH_COLON:  e.value = CH_COLON;
            CH_COMMA:  e.value = CH_BSLASH;
            default: begin
                e.value = c;
                e.bad   = 1'b1;
            end
        endcase
        return e;
    endfunction

endpackage

/* sv/csu_if.sv */
// Valid/ready channel interfaces for raw characters in and decoded results out.
`timescale 1ns / 1ps

interface csu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface csu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       bad_caret;
    logic       bad_escape;
    logic       too_long;
    logic       last;

    modport source (output valid, output kind, output out_byte, output bad_caret,
                    output bad_escape, output too_long, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input bad_caret,
                    input bad_escape, input too_long, input last, output ready);
endinterface

/* sv/csu_cfg.sv */
// APB configuration registers: separator select and too-long limit.
`timescale 1ns / 1ps

module csu_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csu_pkg::ADDR_W-1:0] paddr,
    input  logic [csu_pkg::DATA_W-1:0] pwdata,
    output logic [csu_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output csu_pkg::t_cfg              o_cfg
);
    import csu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic reg_idx;
    logic wr_en;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SEP_COLON:  n_cfg.separator_is_colon = pwdata[0];
                REG_LONG_LIMIT: n_cfg.long_limit         = pwdata[LIMIT_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SEP_COLON:  prdata = DATA_W'(r_cfg.separator_is_colon);
            REG_LONG_LIMIT: prdata = DATA_W'(r_cfg.long_limit);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_is_colon <= 1'b0;
            r_cfg.long_limit         <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* sv/csu_decoder.sv */
// Input register, escape state and single-pass decode of one character into up to two results.
`timescale 1ns / 1ps

module csu_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csu_in_if.sink        i_in,
    input  csu_pkg::t_cfg i_cfg,
    input  logic          i_space,
    output logic          o_push_en,
    output csu_pkg::t_push o_push
);
    import csu_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_in_eoi;

    t_phase             r_phase,  n_phase;
    logic [8:0]         r_oval,   n_oval;
    logic [1:0]         r_odig,   n_odig;
    logic [7:0]         r_prev,   n_prev;
    logic [LIMIT_W-1:0] r_count,  n_count;

    logic               consume;
    logic [7:0]         c;
    logic [7:0]         sep;
    logic               is_oct;
    logic [8:0]         oct_next;
    logic [LIMIT_W-1:0] cnt1;
    logic               tl1;
    logic [7:0]         nb_prev;
    logic [LIMIT_W-1:0] nb_cnt;
    logic [LIMIT_W-1:0] nc_cnt;
    logic               nc_tl;
    logic               do_normal;
    t_esc               esc;
    t_push              push;

    assign consume    = r_in_valid && i_space;
    assign i_in.ready = !r_in_valid || consume;
    assign o_push_en  = consume;
    assign o_push     = push;

    assign c        = r_in_char;
    assign sep      = i_cfg.separator_is_colon ? CH_COLON : CH_COMMA;
    assign is_oct   = (c[7:3] == 5'b00110);
    assign oct_next = {r_oval[5:0], c[2:0]};
    assign cnt1     = sat_inc(r_count);
    assign tl1      = cnt1 > i_cfg.long_limit;
    assign nb_prev  = (r_phase == PH_OCTAL) ? c : r_prev;
    assign nb_cnt   = (r_phase == PH_OCTAL) ? cnt1 : r_count;
    assign nc_cnt   = sat_inc(nb_cnt);
    assign nc_tl    = nc_cnt > i_cfg.long_limit;
    assign esc      = esc_map(c);

    always_comb begin
        n_phase   = r_phase;
        n_oval    = r_oval;
        n_odig    = r_odig;
        n_prev    = r_prev;
        n_count   = r_count;
        push      = '0;
        do_normal = 1'b0;

        if (r_in_eoi) begin
            push.res[0] = end_result((r_phase == PH_NORMAL) ? KIND_EOI : KIND_PREMATURE);
            push.num    = 2'd1;
            n_phase     = PH_NORMAL;
            n_oval      = '0;
            n_odig      = '0;
            n_prev      = '0;
            n_count     = '0;
        end else begin
            unique case (r_phase)
                PH_CARET: begin
                    push.res[0] = byte_result(c & CTRL_MASK,
                                              !(c >= CH_SPACE && c <= CH_TILDE), 1'b0, tl1);
                    push.num    = 2'd1;
                    n_prev      = c;
                    n_count     = cnt1;
                    n_phase     = PH_NORMAL;
                end
                PH_BACKSLASH: begin
                    n_phase = PH_NORMAL;
                    if (is_oct) begin
                        n_phase = PH_OCTAL;
                        n_oval  = {6'b0, c[2:0]};
                        n_odig  = 2'd1;
                    end else if (c != CH_LF) begin
                        push.res[0] = byte_result(esc.value, 1'b0, esc.bad, tl1);
                        push.num    = 2'd1;
                        if (c == CH_COMMA) begin
                            push.res[1] = byte_result(CH_COMMA, 1'b0, 1'b0, tl1);
                            push.num    = 2'd2;
                        end
                        n_prev  = c;
                        n_count = cnt1;
                    end
                end
                PH_OCTAL: begin
                    if (is_oct && r_odig < 2'd2) begin
                        n_oval = oct_next;
                        n_odig = r_odig + 2'd1;
                    end else begin
                        if (is_oct) begin
                            push.res[0] = byte_result((oct_next == '0) ? OCTAL_ZERO
                                                                       : oct_next[7:0],
                                                      1'b0, 1'b0, tl1);
                        end else begin
                            push.res[0] = byte_result((r_oval == '0) ? OCTAL_ZERO
                                                                     : r_oval[7:0],
                                                      1'b0, 1'b0, tl1);
                            do_normal   = 1'b1;
                        end
                        push.num = 2'd1;
                        n_prev   = c;
                        n_count  = cnt1;
                        n_phase  = PH_NORMAL;
                        n_oval   = '0;
                        n_odig   = '0;
                    end
                end
                PH_NORMAL: do_normal = 1'b1;
                default:   do_normal = 1'b1;
            endcase

            if (do_normal) begin
                if (c == sep) begin
                    push.res[push.num[0]] = end_result(KIND_SEP);
                    push.num              = push.num + 2'd1;
                    n_phase               = PH_NORMAL;
                    n_oval                = '0;
                    n_odig                = '0;
                    n_prev                = '0;
                    n_count               = '0;
                end else if (c == CH_CARET && nb_prev != CH_PERCENT) begin
                    n_phase = PH_CARET;
                end else if (c == CH_BSLASH) begin
                    n_phase = PH_BACKSLASH;
                end else begin
                    push.res[push.num[0]] = byte_result(c, 1'b0, 1'b0, nc_tl);
                    push.num              = push.num + 2'd1;
                    n_prev                = c;
                    n_count               = nc_cnt;
                end
            end
        end

        if (push.num == 2'd2) begin
            push.res[1].last = 1'b1;
        end else if (push.num == 2'd1) begin
            push.res[0].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.in_char;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_NORMAL;
            r_oval     <= '0;
            r_odig     <= '0;
            r_prev     <= '0;
            r_count    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (consume) begin
                r_phase <= n_phase;
                r_oval  <= n_oval;
                r_odig  <= n_odig;
                r_prev  <= n_prev;
                r_count <= n_count;
            end
        end
    end

endmodule

/* sv/csu_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
`timescale 1ns / 1ps

module csu_result_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_en,
    input  csu_pkg::t_push i_push,
    output logic           o_space,
    csu_out_if.source      o_res
);
    import csu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0] wr_ptr1;
    logic [1:0]       num;
    logic             pop;
    t_result          head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign num     = i_push_en ? i_push.num : 2'd0;
    assign pop     = o_res.valid && o_res.ready;
    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign o_space = r_count <= CNT_W'(DEPTH - 2);
    assign head    = r_mem[r_rd_ptr];

    assign o_res.valid      = r_count != '0;
    assign o_res.kind       = head.kind;
    assign o_res.out_byte   = head.out_byte;
    assign o_res.bad_caret  = head.bad_caret;
    assign o_res.bad_escape = head.bad_escape;
    assign o_res.too_long   = head.too_long;
    assign o_res.last       = head.last;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (num == 2'd1) begin
            n_wr_ptr = wr_ptr1;
        end else if (num == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res[0];
        end
        if (num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/capability_string_unescaper.sv */
// Top level of the capability string unescaper.
// Usage:
//   i_in carries one raw character per transaction, or an end-of-input mark.
//   o_res carries decoded results: bytes, a separator end, an input end or a
//   premature-end error, with warning flags; last marks the final result of
//   each input transaction.
//   The APB port holds separator_is_colon (0x0) and long_limit (0x4); write
//   them only while the block is idle.
// Throughput: one input transaction per cycle while the queue has two free
//   slots. Every input is decoded combinationally between the input register
//   and result queue; a two-result character takes two output transactions.
// Stall: the result queue (FIFO_DEPTH entries) absorbs results while o_res is
//   held off; i_in.ready drops while a character waits in the input register
//   and fewer than two queue slots remain free.
// Reset: synchronous, active low. It empties the queue and input register,
//   returns the escape state and unit count to zero and the registers to
//   their defaults (comma separator, limit 600). No clearing pass.
`timescale 1ns / 1ps

module capability_string_unescaper #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    csu_in_if.sink                     i_in,
    csu_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csu_pkg::ADDR_W-1:0] paddr,
    input  logic [csu_pkg::DATA_W-1:0] pwdata,
    output logic [csu_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import csu_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  push_en;
    logic  space;

    csu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csu_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (cfg),
        .i_space   (space),
        .o_push_en (push_en),
        .o_push    (push)
    );

    csu_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (push_en),
        .i_push    (push),
        .o_space   (space),
        .o_res     (o_res)
    );

endmodule

/* sv/csu_checker.sv */
// Port-level checks on the result channel and configuration port, bound to the top level.
`timescale 1ns / 1ps

module csu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_kind,
    input logic [7:0] i_out_byte,
    input logic       i_bad_caret,
    input logic       i_bad_escape,
    input logic       i_too_long,
    input logic       i_last,
    input logic       i_pready
);
    import csu_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_out_byte)
                                && $stable(i_last))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_BYTE |-> i_last)
        else $error("string end result not marked last");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_BYTE |-> i_out_byte == 8'h00 && !i_bad_caret
                                           && !i_bad_escape && !i_too_long)
        else $error("string end result carries byte or flags");

    a_single_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_bad_caret && i_bad_escape))
        else $error("caret and escape warnings together");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind capability_string_unescaper csu_checker u_csu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_kind       (o_res.kind),
    .i_out_byte   (o_res.out_byte),
    .i_bad_caret  (o_res.bad_caret),
    .i_bad_escape (o_res.bad_escape),
    .i_too_long   (o_res.too_long),
    .i_last       (o_res.last),
    .i_pready     (pready)
);

/* bench/tb_capability_string_unescaper.sv */
// Self-checking bench for the capability string unescaper: directed table, random strings, stalls.
`timescale 1ns / 1ps

module tb_capability_string_unescaper;
    import csu_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned LONG_STRING_LEN  = 1030;

    localparam logic [ADDR_W-1:0] ADDR_SEP_COLON  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_LONG_LIMIT = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        t_kind      kind;
        logic [7:0] val;
        logic       bc;
        logic       be;
    } t_char_txn;

    localparam logic [7:0] ESCAPE_CHARS [14] = '{
        "E", "e", "l", "n", "r", "b", "s", "f", "t",
        CH_BSLASH, CH_CARET, CH_COLON, CH_COMMA, CH_LF
    };

    localparam t_char_txn DIRECTED [27] = '{
        '{8'h00,      1'b1, 1'b1, KIND_EOI,       8'h00,      1'b0, 1'b0},
        '{8'h00,      1'b0, 1'b1, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{8'hFF,      1'b0, 1'b1, KIND_BYTE,      8'hFF,      1'b0, 1'b0},
        '{CH_CARET,   1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"@",        1'b0, 1'b1, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_CARET,   1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{8'hFF,      1'b0, 1'b1, KIND_BYTE,      8'h1F,      1'b1, 1'b0},
        '{CH_PERCENT, 1'b0, 1'b1, KIND_BYTE,      CH_PERCENT, 1'b0, 1'b0},
        '{CH_CARET,   1'b0, 1'b1, KIND_BYTE,      CH_CARET,   1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"q",        1'b0, 1'b1, KIND_BYTE,      "q",        1'b0, 1'b1},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_COMMA,   1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_LF,      1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"0",        1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"0",        1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"0",        1'b0, 1'b1, KIND_BYTE,      OCTAL_ZERO, 1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{"7",        1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_COMMA,   1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_CARET,   1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{CH_COMMA,   1'b0, 1'b1, KIND_BYTE,      8'h0C,      1'b0, 1'b0},
        '{CH_BSLASH,  1'b0, 1'b0, KIND_BYTE,      8'h00,      1'b0, 1'b0},
        '{8'h00,      1'b1, 1'b1, KIND_PREMATURE, 8'h00,      1'b0, 1'b0},
        '{CH_COMMA,   1'b0, 1'b1, KIND_SEP,       8'h00,      1'b0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    csu_in_if  in_if ();
    csu_out_if res_if ();

    capability_string_unescaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_phase             esc_phase;
    logic [8:0]         oct_value;
    logic [1:0]         oct_digits;
    logic [7:0]         last_char;
    logic [LIMIT_W-1:0] unit_count;
    logic               sep_colon;
    logic [LIMIT_W-1:0] too_long_limit;

    t_result     expected_results[$];
    t_result     step_results[$];
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned settings_count = 0;
    bit          quiet          = 1'b0;
    bit          long_hold      = 1'b0;

    always #10 i_clk = ~i_clk;

    function automatic void add_result(t_kind k, logic [7:0] b, logic bc, logic be, logic tl);
        t_result r;
        r.kind       = k;
        r.out_byte   = b;
        r.bad_caret  = bc;
        r.bad_escape = be;
        r.too_long   = tl;
        r.last       = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic logic count_unit();
        if (unit_count != COUNT_MAX) unit_count = unit_count + 1'b1;
        return unit_count > too_long_limit;
    endfunction

    function automatic void clear_string();
        esc_phase  = PH_NORMAL;
        oct_value  = '0;
        oct_digits = '0;
        last_char  = '0;
        unit_count = '0;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        logic tl;
        if (c == (sep_colon ? CH_COLON : CH_COMMA)) begin
            add_result(KIND_SEP, 8'h00, 1'b0, 1'b0, 1'b0);
            clear_string();
        end else if (c == CH_CARET && last_char != CH_PERCENT) begin
            esc_phase = PH_CARET;
        end else if (c == CH_BSLASH) begin
            esc_phase = PH_BACKSLASH;
        end else begin
            tl = count_unit();
            add_result(KIND_BYTE, c, 1'b0, 1'b0, tl);
            last_char = c;
        end
    endfunction

    function automatic void close_octal(logic [7:0] c);
        logic tl;
        tl = count_unit();
        add_result(KIND_BYTE, (oct_value == 9'd0) ? OCTAL_ZERO : oct_value[7:0],
                   1'b0, 1'b0, tl);
        last_char  = c;
        esc_phase  = PH_NORMAL;
        oct_value  = '0;
        oct_digits = '0;
    endfunction

    function automatic void escaped_char(logic [7:0] c);
        logic [7:0] b;
        logic       bad;
        logic       tl;
        esc_phase = PH_NORMAL;
        if (c >= "0" && c <= "7") begin
            esc_phase  = PH_OCTAL;
            oct_value  = {6'd0, c[2:0]};
            oct_digits = 2'd1;
        end else if (c != CH_LF) begin
            bad = 1'b0;
            case (c)
                "E", "e":  b = CH_ESC;
                "l", "n":  b = CH_LF;
                "r":       b = CH_CR;
                "b":       b = CH_BSPACE;
                "s":       b = CH_SPACE;
                "f":       b = CH_FFEED;
                "t":       b = CH_TAB;
                CH_BSLASH: b = CH_BSLASH;
                CH_CARET:  b = CH_CARET;
                CH_COLON:  b = CH_COLON;
                CH_COMMA:  b = CH_BSLASH;
                default: begin
                    b   = c;
                    bad = 1'b1;
                end
            endcase
            tl = count_unit();
            add_result(KIND_BYTE, b, 1'b0, bad, tl);
            if (c == CH_COMMA) add_result(KIND_BYTE, CH_COMMA, 1'b0, 1'b0, tl);
            last_char = c;
        end
    endfunction

    function automatic void predict_char(t_char_txn t);
        logic    tl;
        t_result r;
        step_results.delete();
        if (t.eoi) begin
            add_result((esc_phase == PH_NORMAL) ? KIND_EOI : KIND_PREMATURE,
                       8'h00, 1'b0, 1'b0, 1'b0);
            clear_string();
        end else begin
            case (esc_phase)
                PH_CARET: begin
                    tl = count_unit();
                    add_result(KIND_BYTE, t.ch & CTRL_MASK,
                               !(t.ch >= CH_SPACE && t.ch <= CH_TILDE), 1'b0, tl);
                    last_char = t.ch;
                    esc_phase = PH_NORMAL;
                end
                PH_BACKSLASH: escaped_char(t.ch);
                PH_OCTAL: begin
                    if (t.ch >= "0" && t.ch <= "7") begin
                        oct_value = {oct_value[5:0], t.ch[2:0]};
                        if (oct_digits >= 2'd2) close_octal(t.ch);
                        else oct_digits = oct_digits + 1'b1;
                    end else begin
                        close_octal(t.ch);
                        plain_char(t.ch);
                    end
                end
                default: plain_char(t.ch);
            endcase
        end
        if (t.typed) begin
            step_results.delete();
            add_result(t.kind, t.val, t.bc, t.be, 1'b0);
        end
        foreach (step_results[i]) begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] plain_pick();
        logic [7:0] c;
        c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
        if (c == CH_CARET || c == CH_BSLASH || c == CH_COMMA || c == CH_COLON)
            c = CH_PERCENT;
        return c;
    endfunction

    function automatic logic [7:0] escape_pick();
        if ($urandom_range(0, 9) < 8) return ESCAPE_CHARS[$urandom_range(0, 13)];
        return 8'($urandom);
    endfunction

    task automatic send_txn(t_char_txn t);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.in_char      <= t.ch;
        in_if.end_of_input <= t.eoi;
        do @(posedge i_clk); while (!in_if.ready);
        predict_char(t);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        t_char_txn t;
        t       = '0;
        t.ch    = c;
        t.kind  = KIND_BYTE;
        send_txn(t);
    endtask

    task automatic send_eoi();
        t_char_txn t;
        t      = '0;
        t.ch   = 8'($urandom);
        t.eoi  = 1'b1;
        t.kind = KIND_BYTE;
        send_txn(t);
    endtask

    task automatic send_well_formed(int unsigned units);
        int unsigned sel;
        repeat (units) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_char(plain_pick());
            end else if (sel < 60) begin
                send_char(CH_CARET);
                send_char((sel < 57) ? 8'($urandom_range(32, 126)) : 8'($urandom));
            end else if (sel < 80) begin
                send_char(CH_BSLASH);
                send_char(escape_pick());
            end else if (sel < 95) begin
                send_char(CH_BSLASH);
                repeat ($urandom_range(1, 3)) send_char(8'("0" + $urandom_range(0, 7)));
            end else begin
                send_char(8'($urandom));
            end
        end
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            send_char(sep_colon ? CH_COLON : CH_COMMA);
        end else if (sel < 90) begin
            send_eoi();
        end else begin
            send_char((sel < 95) ? CH_CARET : CH_BSLASH);
            send_eoi();
        end
    endtask

    task automatic send_noise(int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) send_eoi();
            else send_char(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SEP_COLON) sep_colon = data[0];
        else too_long_limit = data[LIMIT_W-1:0];
    endtask

    task automatic run_phase(logic colon, logic [LIMIT_W-1:0] limit, int unsigned n_items,
                             bit hold, bit calm);
        int unsigned start;
        wait_idle();
        write_reg(ADDR_SEP_COLON, {31'($urandom), colon});
        write_reg(ADDR_LONG_LIMIT, {22'($urandom), limit});
        settings_count++;
        quiet     = calm;
        long_hold = hold;
        start     = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 9) < 8) send_well_formed($urandom_range(0, 20));
            else send_noise($urandom_range(1, 12));
        end
    endtask

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: kind %0d, out_byte %0h",
                       res_if.kind, res_if.out_byte);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("kind", exp_r.kind, res_if.kind);
                check_field("out_byte", exp_r.out_byte, res_if.out_byte);
                check_field("bad_caret", exp_r.bad_caret, res_if.bad_caret);
                check_field("bad_escape", exp_r.bad_escape, res_if.bad_escape);
                check_field("too_long", exp_r.too_long, res_if.too_long);
                check_field("last", exp_r.last, res_if.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned n;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            n = pick_gap();
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_if.valid        <= 1'b0;
        in_if.in_char      <= '0;
        in_if.end_of_input <= 1'b0;
        clear_string();
        sep_colon      = 1'b0;
        too_long_limit = LIMIT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_txn(DIRECTED[i]);

        run_phase(1'b0, 10'd0,    15, 1'b0, 1'b0);
        run_phase(1'b1, 10'd1023, 15, 1'b0, 1'b1);
        run_phase(1'b1, 10'd3,    40, 1'b1, 1'b0);
        run_phase(1'b0, 10'd600,  15, 1'b0, 1'b0);
        run_phase(1'b0, 10'd1022, 10, 1'b0, 1'b0);
        // push the unit count past the limit and into saturation
        repeat (LONG_STRING_LEN) send_char(plain_pick());
        send_char(CH_COMMA);
        run_phase(1'b1, 10'($urandom), 15, 1'b0, 1'b0);
        run_phase(1'b0, 10'($urandom_range(0, 40)), 40, 1'b1, 1'b0);
        run_phase(1'b1, 10'd10,   15, 1'b0, 1'b1);

        wait_idle();
        $display("Sent %0d characters and end marks under %0d register settings, checked %0d results",
                 items_sent, settings_count, results_seen);
        $display("Exercised carets, backslash and octal escapes, both separators, %s",
                 "premature ends, saturating unit counts and long output stalls");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
